// ===== rtl/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and register codes for the smoothstep window transfer block.
// ----------------------------------------------------------------------------
package sws_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_RED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GREEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BLUE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_RED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GREEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BLUE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_RADIUS = 3'd6;

    // number of soft edges: three lower, three upper
    localparam int EDGE_COUNT = 6;

    // where the sample sits relative to one soft edge
    typedef struct packed {
        logic below;
        logic above;
    } edge_cls_t;

endpackage

// ===== rtl/sws_div.sv =====
// ----------------------------------------------------------------------------
// sws_div
// Pipelined restoring divider, one quotient bit per stage: t = (n << F) / d.
// ----------------------------------------------------------------------------
module sws_div
    import sws_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                   clk,
    input  logic [FRAC_BITS-1:0]   en,
    input  logic [FRAC_BITS+3:0]   divisor,
    input  logic [FRAC_BITS+3:0]   dividend,
    input  edge_cls_t              cls_in,
    output logic [FRAC_BITS-1:0]   quot,
    output edge_cls_t              cls_out
);

    localparam int F = FRAC_BITS;
    localparam int W = FRAC_BITS + 4;

    logic [W-1:0] rem_reg  [F];
    logic [F-1:0] quot_reg [F];
    edge_cls_t    cls_reg  [F];

    genvar i;
    generate
        for (i = 0; i < F; i++)
        begin : g_stage
            logic [W-1:0] rem_in;
            logic [F-1:0] quot_in;
            edge_cls_t    cls_i;
            logic [W:0]   rem_sh;
            logic         fits;

            if (i == 0)
            begin : g_first
                assign rem_in  = dividend;
                assign quot_in = '0;
                assign cls_i   = cls_in;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[i-1];
                assign quot_in = quot_reg[i-1];
                assign cls_i   = cls_reg[i-1];
            end

            // shift and trial subtract
            assign rem_sh = {rem_in, 1'b0};
            assign fits   = rem_sh >= {1'b0, divisor};

            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    rem_reg[i]  <= fits ? W'(rem_sh - {1'b0, divisor}) : W'(rem_sh);
                    quot_reg[i] <= {quot_in[F-2:0], fits};
                    cls_reg[i]  <= cls_i;
                end
            end
        end
    endgenerate

    assign quot    = quot_reg[F-1];
    assign cls_out = cls_reg[F-1];

endmodule

// ===== rtl/sws_shape.sv =====
// ----------------------------------------------------------------------------
// sws_shape
// Smoothstep polynomial t*t*(3-2t) in two multiply stages, edge clamping.
// ----------------------------------------------------------------------------
module sws_shape
    import sws_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                 clk,
    input  logic [1:0]           en,
    input  logic [FRAC_BITS-1:0] t,
    input  edge_cls_t            cls_in,
    output logic [FRAC_BITS:0]   s
);

    localparam int F = FRAC_BITS;
    localparam logic [F+1:0] THREE = (F+2)'(3) << F;
    localparam logic [F:0]   ONE   = (F+1)'(1) << F;

    logic [F-1:0]   t2_reg;
    logic [F-1:0]   t_reg;
    edge_cls_t      cls_reg;
    logic [F:0]     s_reg;
    logic [2*F-1:0] sq;
    logic [F+1:0]   coef;
    logic [2*F+1:0] prod;

    // stage one: square
    assign sq = (2*F)'(t) * (2*F)'(t);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t2_reg  <= sq[2*F-1:F];
            t_reg   <= t;
            cls_reg <= cls_in;
        end
    end

    // stage two: times (3 - 2t), then clamp outside the edges
    assign coef = THREE - (F+2)'({t_reg, 1'b0});
    assign prod = (2*F+2)'(t2_reg) * (2*F+2)'(coef);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            if (cls_reg.below)
                s_reg <= '0;
            else if (cls_reg.above)
                s_reg <= ONE;
            else
                s_reg <= prod[2*F:F];
        end
    end

    assign s = s_reg;

endmodule

// ===== rtl/smoothstep_window_transfer_top.sv =====
// ----------------------------------------------------------------------------
// smoothstep_window_transfer_top
// Soft window transfer function: three channel weights and their peak.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes the window registers (index 0..6); cfg_ready is always
//   high, and writes belong to idle periods only. Indexes above six are ignored.
//   in channel takes one signed sample beat; out channel gives one beat with
//   red, green, blue and peak weights for every sample, in order.
// Pipeline: classify stage, the one-bit-per-stage divider, then two
//   polynomial stages, a weight stage and an output stage.
// Throughput: one sample per cycle while out_ready is high; every stage
//   has its own valid bit.
// Stall: when the receiver holds out_ready low the output stage holds and
//   stages behind it keep filling bubbles; in_ready drops only once every
//   stage holds a beat. Nothing is lost or repeated.
// Reset: clears all valid bits and loads the default windows (low 0.5,
//   high 1.5, radius 0.5).
// ----------------------------------------------------------------------------
module smoothstep_window_transfer_top
    import sws_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [FRAC_BITS+3:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FRAC_BITS+3:0]   sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FRAC_BITS:0]     red_weight,
    output logic [FRAC_BITS:0]     green_weight,
    output logic [FRAC_BITS:0]     blue_weight,
    output logic [FRAC_BITS:0]     peak_weight
);

    localparam int F   = FRAC_BITS;
    localparam int W   = FRAC_BITS + 4;
    localparam int NST = FRAC_BITS + 5;
    localparam int ST_DIV   = 1;
    localparam int ST_SHAPE = FRAC_BITS + 1;
    localparam int ST_WT    = FRAC_BITS + 3;
    localparam int ST_OUT   = FRAC_BITS + 4;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    // configuration registers
    logic [W-1:0] center_reg [EDGE_COUNT];
    logic [W-2:0] radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= W'(1) << (F-1);
            center_reg[1] <= W'(1) << (F-1);
            center_reg[2] <= W'(1) << (F-1);
            center_reg[3] <= W'(3) << (F-1);
            center_reg[4] <= W'(3) << (F-1);
            center_reg[5] <= W'(3) << (F-1);
            radius_reg    <= (W-1)'(1) << (F-1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOW_RED:     center_reg[0] <= cfg_data;
                REG_LOW_GREEN:   center_reg[1] <= cfg_data;
                REG_LOW_BLUE:    center_reg[2] <= cfg_data;
                REG_HIGH_RED:    center_reg[3] <= cfg_data;
                REG_HIGH_GREEN:  center_reg[4] <= cfg_data;
                REG_HIGH_BLUE:   center_reg[5] <= cfg_data;
                REG_SOFT_RADIUS: radius_reg    <= cfg_data[W-2:0];
                default:         ;
            endcase
        end
    end

    // pipeline control: a stage may load when empty or when its successor moves
    logic [NST-1:0] valid_reg;
    logic [NST:0]   rdy;

    assign rdy[NST] = out_ready;

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_ctl
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (rdy[0])
                valid_reg[0] <= in_valid;
            for (int j = 1; j < NST; j++)
            begin
                if (rdy[j])
                    valid_reg[j] <= valid_reg[j-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NST-1];

    logic [W-1:0] divisor;
    assign divisor = {radius_reg, 1'b0};

    // per edge: classify, divide, shape
    logic [F:0] s_edge [EDGE_COUNT];

    genvar e;
    generate
        for (e = 0; e < EDGE_COUNT; e++)
        begin : g_edge
            logic signed [W+1:0] x_ext;
            logic signed [W+1:0] lo_edge;
            logic signed [W+1:0] hi_edge;
            logic signed [W+1:0] diff;
            edge_cls_t           cls_next;
            edge_cls_t           cls_reg;
            logic [W-1:0]        num_reg;
            logic [F-1:0]        t_q;
            edge_cls_t           cls_q;

            assign x_ext   = $signed({{2{sample[W-1]}}, sample});
            assign lo_edge = $signed({{2{center_reg[e][W-1]}}, center_reg[e]})
                             - $signed({3'b000, radius_reg});
            assign hi_edge = $signed({{2{center_reg[e][W-1]}}, center_reg[e]})
                             + $signed({3'b000, radius_reg});
            assign diff    = x_ext - lo_edge;
            assign cls_next.below = x_ext < lo_edge;
            assign cls_next.above = x_ext >= hi_edge;

            // classify stage
            always_ff @(posedge clk)
            begin
                if (rdy[0])
                begin
                    cls_reg <= cls_next;
                    num_reg <= diff[W-1:0];
                end
            end

            sws_div #(
                .FRAC_BITS (F)
            ) u_div (
                .clk      (clk),
                .en       (rdy[ST_DIV+F-1:ST_DIV]),
                .divisor  (divisor),
                .dividend (num_reg),
                .cls_in   (cls_reg),
                .quot     (t_q),
                .cls_out  (cls_q)
            );

            sws_shape #(
                .FRAC_BITS (F)
            ) u_shape (
                .clk    (clk),
                .en     (rdy[ST_SHAPE+1:ST_SHAPE]),
                .t      (t_q),
                .cls_in (cls_q),
                .s      (s_edge[e])
            );
        end
    endgenerate

    // window weight per channel: s_low * (1 - s_high)
    logic [F:0] wt_reg [3];

    generate
        for (e = 0; e < 3; e++)
        begin : g_wt
            logic [F:0]     inv;
            logic [2*F+1:0] prod;

            assign inv  = ONE - s_edge[e+3];
            assign prod = (2*F+2)'(s_edge[e]) * (2*F+2)'(inv);

            always_ff @(posedge clk)
            begin
                if (rdy[ST_WT])
                    wt_reg[e] <= prod[2*F:F];
            end
        end
    endgenerate

    // output stage with peak select
    logic [F:0] red_reg;
    logic [F:0] green_reg;
    logic [F:0] blue_reg;
    logic [F:0] peak_reg;
    logic [F:0] peak_next;

    always_comb
    begin
        peak_next = wt_reg[0];
        if (wt_reg[1] > peak_next)
            peak_next = wt_reg[1];
        if (wt_reg[2] > peak_next)
            peak_next = wt_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
        begin
            red_reg   <= wt_reg[0];
            green_reg <= wt_reg[1];
            blue_reg  <= wt_reg[2];
            peak_reg  <= peak_next;
        end
    end

    assign red_weight   = red_reg;
    assign green_weight = green_reg;
    assign blue_weight  = blue_reg;
    assign peak_weight  = peak_reg;

endmodule

// ===== tb/tb_smoothstep_window_transfer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_smoothstep_window_transfer_top
// Self-checking bench for the smoothstep window transfer block: samples are
// streamed under random idling on both sides, each output beat is compared
// with a predicted weight set, and window settings change between phases.
// ----------------------------------------------------------------------------
module tb_smoothstep_window_transfer_top;
    import sws_pkg::*;

    localparam int FB = 12;
    localparam int ONE = 1 << FB;
    localparam int DRAIN_CYCLES = FB + 10;
    // index past the last register, ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [FB:0] red;
        logic [FB:0] green;
        logic [FB:0] blue;
        logic [FB:0] peak;
    } weight_set_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FB+3:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [FB+3:0] sample;
    logic out_valid;
    logic out_ready;
    logic [FB:0] red_weight;
    logic [FB:0] green_weight;
    logic [FB:0] blue_weight;
    logic [FB:0] peak_weight;

    // window registers as the bench believes them
    int lo_edge [3];
    int hi_edge [3];
    int radius;

    weight_set_t expected_weights [$];
    int mismatch_count;
    int beats_sent;
    int beats_checked;
    int cfg_writes;
    bit calm_mode;

    smoothstep_window_transfer_top #(.FRAC_BITS(FB)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_weight(red_weight), .green_weight(green_weight),
        .blue_weight(blue_weight), .peak_weight(peak_weight)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // fixed-point smoothstep between edges a and b
    function automatic longint soft_edge(longint a, longint b, longint x);
        longint t;
        longint t2;
        begin
            if (x < a)
                return 0;
            if (x >= b)
                return ONE;
            t = ((x - a) <<< FB) / (b - a);
            t2 = (t * t) >>> FB;
            return (t2 * (3 * ONE - 2 * t)) >>> FB;
        end
    endfunction

    function automatic weight_set_t predict_weights(logic [FB+3:0] x_raw);
        longint x;
        longint s_lo;
        longint s_hi;
        longint w [3];
        weight_set_t r;
        begin
            x = longint'($signed(x_raw));
            for (int c = 0; c < 3; c++)
            begin
                s_lo = soft_edge(lo_edge[c] - radius, lo_edge[c] + radius, x);
                s_hi = soft_edge(hi_edge[c] - radius, hi_edge[c] + radius, x);
                w[c] = (s_lo * (ONE - s_hi)) >>> FB;
            end
            r.red = w[0][FB:0];
            r.green = w[1][FB:0];
            r.blue = w[2][FB:0];
            r.peak = w[0][FB:0];
            if (w[1][FB:0] > r.peak) r.peak = w[1][FB:0];
            if (w[2][FB:0] > r.peak) r.peak = w[2][FB:0];
            return r;
        end
    endfunction

    // random idle decision, off during calm stretches
    function automatic bit idle_now();
        return !calm_mode && ($urandom_range(99) < 10);
    endfunction

    // send one sample beat; valid stays up for a following beat
    task automatic send_sample(logic [FB+3:0] value);
        begin
            while (idle_now())
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            sample <= value;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            expected_weights.push_back(predict_weights(value));
            beats_sent++;
        end
    endtask

    // wait for the pipeline to empty before touching registers
    task automatic drain_pipe();
        begin
            in_valid <= 1'b0;
            while (expected_weights.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // one register write; valid stays up for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FB+3:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_writes++;
            case (idx)
                REG_LOW_RED:     lo_edge[0] = $signed(value);
                REG_LOW_GREEN:   lo_edge[1] = $signed(value);
                REG_LOW_BLUE:    lo_edge[2] = $signed(value);
                REG_HIGH_RED:    hi_edge[0] = $signed(value);
                REG_HIGH_GREEN:  hi_edge[1] = $signed(value);
                REG_HIGH_BLUE:   hi_edge[2] = $signed(value);
                REG_SOFT_RADIUS: radius = int'(value[FB+2:0]);
                default: ;
            endcase
        end
    endtask

    task automatic set_windows(int lr, int lg, int lb, int hr, int hg, int hb, int rad);
        begin
            drain_pipe();
            write_reg(REG_LOW_RED, lr[15:0]);
            write_reg(REG_LOW_GREEN, lg[15:0]);
            write_reg(REG_LOW_BLUE, lb[15:0]);
            write_reg(REG_HIGH_RED, hr[15:0]);
            write_reg(REG_HIGH_GREEN, hg[15:0]);
            write_reg(REG_HIGH_BLUE, hb[15:0]);
            write_reg(REG_SOFT_RADIUS, rad[15:0]);
            cfg_valid <= 1'b0;
        end
    endtask

    // output beat checker
    always @(posedge clk)
    begin
        weight_set_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_weights.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output beat at %0t", $realtime);
            end
            else
            begin
                exp_w = expected_weights.pop_front();
                beats_checked++;
                if (exp_w.red !== red_weight || exp_w.green !== green_weight ||
                    exp_w.blue !== blue_weight || exp_w.peak !== peak_weight)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp r%0d g%0d b%0d p%0d got r%0d g%0d b%0d p%0d",
                                 exp_w.red, exp_w.green, exp_w.blue, exp_w.peak,
                                 red_weight, green_weight, blue_weight, peak_weight);
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= !idle_now();
    end

    task automatic test_reset_windows();
        begin
            send_sample(16'sh8000);
            send_sample(16'sh7fff);
            send_sample(16'd0);
            send_sample(16'd1024);
            send_sample(16'd2048);
            send_sample(16'd4095);
            send_sample(16'd4096);
            send_sample(16'd6144);
            send_sample(16'd8191);
            send_sample(16'd8192);
            send_sample(16'hffff);
        end
    endtask

    task automatic test_zero_radius();
        begin
            set_windows(-4096, 0, 100, 4096, 8192, 50, 0);
            send_sample(16'hf000);
            send_sample(16'hefff);
            send_sample(16'd0);
            send_sample(16'd99);
            send_sample(16'd100);
            send_sample(16'd4096);
            send_sample(16'd8191);
        end
    endtask

    task automatic test_extreme_windows();
        begin
            // widest radius with extreme centers, and a reversed window
            set_windows(-32768, 32767, 0, 32767, -32768, 16384, 32767);
            send_sample(16'sh8000);
            send_sample(16'sh7fff);
            send_sample(16'd0);
            send_sample(16'h4000);
            // ignored indexes leave the windows alone
            drain_pipe();
            write_reg(REG_UNMAPPED, 16'h1234);
            cfg_valid <= 1'b0;
            send_sample(16'h0101);
        end
    endtask

    task automatic test_random_stream();
        int lr, lg, lb, hr, hg, hb, rad;
        int centre;
        begin
            for (int phase = 0; phase < 11; phase++)
            begin
                calm_mode = (phase == 5);
                if (phase % 3 == 0)
                begin
                    lr = $signed(16'($urandom)); lg = $signed(16'($urandom));
                    lb = $signed(16'($urandom)); hr = $signed(16'($urandom));
                    hg = $signed(16'($urandom)); hb = $signed(16'($urandom));
                    rad = $urandom_range(32767);
                end
                else
                begin
                    // well-formed windows with random placement
                    centre = $urandom_range(24000) - 12000;
                    lr = centre; lg = centre + $urandom_range(2000);
                    lb = centre - $urandom_range(2000);
                    hr = lr + $urandom_range(8000); hg = lg + $urandom_range(8000);
                    hb = lb + $urandom_range(8000);
                    rad = (phase == 4) ? 0 : $urandom_range(4096);
                end
                set_windows(lr, lg, lb, hr, hg, hb, rad);
                for (int k = 0; k < 100; k++)
                begin
                    if ($urandom_range(3) == 0)
                        send_sample(16'($urandom));
                    else
                        send_sample(16'(lr - rad - 512 + $urandom_range(hr - lr + 2 * rad + 1024)));
                end
            end
            calm_mode = 1'b0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample = '0;
        out_ready = 1'b0;
        calm_mode = 1'b0;
        mismatch_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        cfg_writes = 0;
        for (int c = 0; c < 3; c++)
        begin
            lo_edge[c] = 2048;
            hi_edge[c] = 6144;
        end
        radius = 2048;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_windows();
        test_zero_radius();
        test_extreme_windows();
        test_random_stream();
        drain_pipe();

        $display("covered %0d sample beats, %0d checked, %0d register writes",
                 beats_sent, beats_checked, cfg_writes);
        $display("windows: reset, hard step, extremes, reversed, random well-formed");
        if (mismatch_count == 0 && expected_weights.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sws_pkg.sv
rtl/sws_div.sv
rtl/sws_shape.sv
rtl/smoothstep_window_transfer_top.sv
tb/tb_smoothstep_window_transfer_top.sv
